### design/apq_pkg.sv
// shared types and constants for the aging priority queue
// used by apq_age_cmp and aging_priority_queue_core; no dependencies
`timescale 1ns / 1ps

package apq_pkg;

   // field widths
   localparam int LEVEL_W  = 3;
   localparam int RANK_W   = 5;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int AGE_W    = 10;
   localparam int FLOOR_W  = 3;
   localparam int REQ_W    = 40;
   // (aging_minutes + 1) * 60 stays below 2^17
   localparam int THR_W    = 17;

   localparam int SECONDS_PER_MINUTE = 60;

   localparam logic [AGE_W-1:0]   AGING_RESET = 10'd30;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = 3'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED  = 2'd0,
      ST_SERVED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic {
      CSR_AGING_MINUTES  = 1'b0,
      CSR_NO_AGING_FLOOR = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   // one stored queue entry
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [RANK_W-1:0]  rank;
      logic [WORD_W-1:0]  number;
      logic [WORD_W-1:0]  seconds;
   } entry_type;

   // entry together with its aged level
   typedef struct packed {
      logic [LEVEL_W-1:0] eff;
      entry_type          ent;
   } cand_type;

   // aging controls that hold still for one item
   typedef struct packed {
      logic [WORD_W-1:0]  now;
      logic [THR_W-1:0]   threshold;
      logic [FLOOR_W-1:0] floor;
   } age_ctl_type;

   // result fields apart from the entry count
   typedef struct packed {
      status_type         status;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] eff;
      logic [RANK_W-1:0]  rank;
      logic [WORD_W-1:0]  number;
      logic [WORD_W-1:0]  seconds;
      logic [WORD_W-1:0]  wait_s;
   } result_type;

endpackage

### design/aging_priority_queue_core.sv
// aging priority queue: entry memory, scan and shift sequencer, output register
// depends on apq_pkg and apq_age_cmp
`timescale 1ns / 1ps

// Usage
// req channel: tuser is the mode (0 add, 1 serve); tdata carries now_seconds,
// level and symptom_rank. Every item gives exactly one rsp item whose tuser is
// the status (added, served, empty, full) and whose tdata carries the served
// entry and the entry count left.
// Entries sit in one memory of QUEUE_DEPTH words with a registered read.
// An add, a full add or a serve of an empty queue writes at most one word and
// passes its result through the result register to the output register.
// A serve with N entries stored reads all N words through the aging compare,
// then moves the entries behind the winner down one slot, one read and one
// write per cycle, then loads the result into the result register.
// One item is worked at a time; req_tready is high while the sequencer is idle,
// and a new item is taken while the previous result still waits in the output
// register. A stalled receiver holds the result there and, once the next item
// is finished, holds the sequencer too.
// Reset empties the queue, restarts arrival numbers at zero and loads the
// register defaults (30 minutes, floor 2); memory contents are not cleared.
// csr writes are taken at any edge with csr_we high and belong in idle time.

module aging_priority_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   localparam int IDX_W    = $clog2(QUEUE_DEPTH),
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_BITS = 107 + CNT_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // now_seconds[31:0], level[34:32], symptom_rank[39:35]
   input  logic [apq_pkg::REQ_W-1:0]   req_tdata,
   // mode[0]
   input  logic                        req_tuser,
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // served_level[2:0], effective_level[5:3], served_rank[10:6],
   // arrival_number[42:11], arrival_seconds[74:43], wait_seconds[106:75],
   // entries_left[106+CNT_W:107], zero fill above
   output logic [RSP_W-1:0]            rsp_tdata,
   // status[1:0]
   output logic [apq_pkg::STATUS_W-1:0] rsp_tuser,
   // register writes
   input  logic                        csr_we,
   input  logic [0:0]                  csr_addr,
   input  logic [apq_pkg::AGE_W-1:0]   csr_wdata
);

   apq_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [apq_pkg::WORD_W-1:0] next_num_ff, next_num_in;
   logic [apq_pkg::WORD_W-1:0] now_ff, now_in;
   logic [apq_pkg::AGE_W-1:0]   aging_ff;
   logic [apq_pkg::FLOOR_W-1:0] floor_ff;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   apq_pkg::cand_type    best_ff, best_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   apq_pkg::result_type  res_ff, res_in;
   logic [CNT_W-1:0]     res_left_ff, res_left_in;
   logic                 rsp_valid_ff;
   apq_pkg::result_type  rsp_res_ff;
   logic [CNT_W-1:0]     rsp_left_ff;
   logic                 load_rsp;

   // entry memory ports
   apq_pkg::entry_type   mem [QUEUE_DEPTH];
   apq_pkg::entry_type   rd_data_ff;
   logic                 mem_we, mem_re;
   logic [IDX_W-1:0]     mem_wa, mem_ra;
   apq_pkg::entry_type   mem_wd;

   // request fields
   logic [apq_pkg::WORD_W-1:0]  req_now;
   logic [apq_pkg::LEVEL_W-1:0] req_level;
   logic [apq_pkg::RANK_W-1:0]  req_rank;

   // compare unit
   apq_pkg::age_ctl_type        age_ctl;
   logic [apq_pkg::LEVEL_W-1:0] cand_eff;
   logic                        cand_wins;

   assign req_now   = req_tdata[31:0];
   assign req_level = req_tdata[34:32];
   assign req_rank  = req_tdata[39:35];

   // aging threshold in seconds from the minute limit
   always_comb begin
      age_ctl.now       = now_ff;
      age_ctl.floor     = floor_ff;
      age_ctl.threshold = apq_pkg::THR_W'(
         ({7'd0, aging_ff} + apq_pkg::THR_W'(1)) *
         apq_pkg::THR_W'(apq_pkg::SECONDS_PER_MINUTE));
   end

   apq_age_cmp u_age_cmp (
      .ctl       (age_ctl),
      .cand      (rd_data_ff),
      .best      (best_ff),
      .cand_eff  (cand_eff),
      .cand_wins (cand_wins)
   );

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         aging_ff <= apq_pkg::AGING_RESET;
         floor_ff <= apq_pkg::FLOOR_RESET;
      end else if (csr_we) begin
         unique case (apq_pkg::csr_index_type'(csr_addr))
            apq_pkg::CSR_AGING_MINUTES:  aging_ff <= csr_wdata;
            apq_pkg::CSR_NO_AGING_FLOOR: floor_ff <= csr_wdata[apq_pkg::FLOOR_W-1:0];
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= apq_pkg::S_IDLE;
         count_ff    <= '0;
         next_num_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         next_num_ff <= next_num_in;
         pend_ff     <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rd_ptr_ff   <= rd_ptr_in;
      pend_idx_ff <= pend_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      res_ff      <= res_in;
      res_left_ff <= res_left_in;
   end

   // sequencer: accept, scan for the winner, close the gap, hand off the result
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      next_num_in = next_num_ff;
      now_in      = now_ff;
      rd_ptr_in   = rd_ptr_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      res_in      = res_ff;
      res_left_in = res_left_ff;
      mem_we      = 1'b0;
      mem_wa      = pend_idx_ff;
      mem_wd      = rd_data_ff;
      mem_re      = 1'b0;
      mem_ra      = rd_ptr_ff[IDX_W-1:0];
      req_tready  = 1'b0;
      load_rsp    = 1'b0;

      unique case (state_ff)
         apq_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               now_in      = req_now;
               res_in      = '0;
               res_left_in = count_ff;
               state_in    = apq_pkg::S_DONE;
               priority if (!req_tuser) begin
                  if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     res_in.status = apq_pkg::ST_FULL;
                  end else begin
                     mem_we         = 1'b1;
                     mem_wa         = count_ff[IDX_W-1:0];
                     mem_wd.level   = req_level;
                     mem_wd.rank    = req_rank;
                     mem_wd.number  = next_num_ff;
                     mem_wd.seconds = req_now;
                     next_num_in    = next_num_ff + apq_pkg::WORD_W'(1);
                     count_in       = count_ff + CNT_W'(1);
                     res_left_in    = count_ff + CNT_W'(1);
                     res_in.status  = apq_pkg::ST_ADDED;
                  end
               end else if (count_ff == '0) begin
                  res_in.status = apq_pkg::ST_EMPTY;
               end else begin
                  rd_ptr_in = '0;
                  state_in  = apq_pkg::S_SCAN;
               end
            end
         end

         apq_pkg::S_SCAN: begin
            // issue the next read while the previous word is compared
            if (rd_ptr_ff < count_ff) begin
               mem_re      = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
            end
            if (pend_ff && (pend_idx_ff == '0 || cand_wins)) begin
               best_in.eff = cand_eff;
               best_in.ent = rd_data_ff;
               best_idx_in = pend_idx_ff;
            end
            if (rd_ptr_ff >= count_ff && !pend_ff) begin
               rd_ptr_in = CNT_W'(best_idx_ff) + CNT_W'(1);
               state_in  = apq_pkg::S_SHIFT;
            end
         end

         apq_pkg::S_SHIFT: begin
            // read slot p, write it into slot p - 1 in the following cycle
            if (rd_ptr_ff < count_ff) begin
               mem_re      = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = IDX_W'(rd_ptr_ff - CNT_W'(1));
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (rd_ptr_ff >= count_ff && !pend_ff) begin
               count_in       = count_ff - CNT_W'(1);
               res_left_in    = count_ff - CNT_W'(1);
               res_in.status  = apq_pkg::ST_SERVED;
               res_in.level   = best_ff.ent.level;
               res_in.eff     = best_ff.eff;
               res_in.rank    = best_ff.ent.rank;
               res_in.number  = best_ff.ent.number;
               res_in.seconds = best_ff.ent.seconds;
               res_in.wait_s  = now_ff - best_ff.ent.seconds;
               state_in       = apq_pkg::S_DONE;
            end
         end

         apq_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = apq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = apq_pkg::S_IDLE;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_res_ff  <= res_ff;
         rsp_left_ff <= res_left_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = RSP_W'({rsp_left_ff, rsp_res_ff.wait_s, rsp_res_ff.seconds,
                               rsp_res_ff.number, rsp_res_ff.rank, rsp_res_ff.eff,
                               rsp_res_ff.level});

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_count_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == apq_pkg::S_SCAN || state_ff == apq_pkg::S_SHIFT) |->
      $stable(count_ff))
      else $error("entry count moved during a serve");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == apq_pkg::S_SHIFT && pend_ff) |->
      (CNT_W'(pend_idx_ff) + CNT_W'(1) < count_ff))
      else $error("shift write outside the held entries");

   a_empty_left: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && res_ff.status == apq_pkg::ST_EMPTY) |-> (res_left_ff == '0))
      else $error("empty result with entries left");

endmodule

### design/apq_age_cmp.sv
// aged level of one candidate entry and its comparison against the best so far
// depends on apq_pkg
`timescale 1ns / 1ps

module apq_age_cmp (
   input  apq_pkg::age_ctl_type        ctl,
   input  apq_pkg::entry_type          cand,
   input  apq_pkg::cand_type           best,
   output logic [apq_pkg::LEVEL_W-1:0] cand_eff,
   output logic                        cand_wins
);

   logic [apq_pkg::WORD_W-1:0] waited;
   logic                       aged;

   // whole minutes exceed the limit exactly when waited >= (limit + 1) * 60
   always_comb begin
      waited = ctl.now - cand.seconds;
      aged   = (cand.level > ctl.floor) &&
               (waited >= apq_pkg::WORD_W'(ctl.threshold));
      cand_eff = aged ? cand.level - apq_pkg::LEVEL_W'(1) : cand.level;
   end

   // level, then rank, then arrival number; a full tie keeps the earlier slot
   always_comb begin
      priority if (cand_eff != best.eff) begin
         cand_wins = cand_eff < best.eff;
      end else if (cand.rank != best.ent.rank) begin
         cand_wins = cand.rank < best.ent.rank;
      end else begin
         cand_wins = cand.number < best.ent.number;
      end
   end

endmodule

### tb/tb_aging_priority_queue_core.sv
// self-checking testbench for aging_priority_queue_core: stream driver, monitor, queue model
// depends on apq_pkg and the design files under design/
`timescale 1ns / 1ps

module tb_aging_priority_queue_core;

   localparam int DEPTH       = 16;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int RSP_W       = ((107 + CNT_W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_SERVE = 1'b1;

   typedef struct {
      logic                        mode;
      logic [apq_pkg::WORD_W-1:0]  now;
      logic [apq_pkg::LEVEL_W-1:0] level;
      logic [apq_pkg::RANK_W-1:0]  rank;
   } queue_request_type;

   typedef struct packed {
      apq_pkg::result_type res;
      logic [CNT_W-1:0]    left;
   } queue_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [apq_pkg::REQ_W-1:0]    req_tdata  = '0;
   logic                         req_tuser  = MODE_ADD;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_W-1:0]             rsp_tdata;
   logic [apq_pkg::STATUS_W-1:0] rsp_tuser;
   logic                         csr_we     = 1'b0;
   logic [0:0]                   csr_addr   = '0;
   logic [apq_pkg::AGE_W-1:0]    csr_wdata  = '0;

   // stimulus backlog and results still due from the block
   queue_request_type request_backlog[$];
   queue_outcome_type queue_results_due[$];

   // model of the queue contents and registers
   apq_pkg::entry_type          model_slot[DEPTH];
   int                          model_count;
   logic [apq_pkg::WORD_W-1:0]  model_next_number;
   logic [apq_pkg::AGE_W-1:0]   model_aging;
   logic [apq_pkg::FLOOR_W-1:0] model_floor;

   int send_idle_pct = 10;
   int recv_idle_pct = 76;
   int items_taken   = 0;
   int items_pushed  = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   logic          hold_toggle = 1'b0;
   logic          hold_seen   = 1'b0;
   int            hold_left   = 0;
   logic [apq_pkg::WORD_W-1:0] stim_seconds = '0;
   int            burst_left  = 0;
   logic          burst_mode  = MODE_ADD;

   aging_priority_queue_core #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_aging_priority_queue_core: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [apq_pkg::WORD_W-1:0] got,
                                  logic [apq_pkg::WORD_W-1:0] want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // aged level of a stored entry at serve time
   function automatic logic [apq_pkg::LEVEL_W-1:0] promoted_level(apq_pkg::entry_type e,
                                                                 logic [apq_pkg::WORD_W-1:0] now);
      logic [apq_pkg::WORD_W-1:0] waited_min;
      waited_min = (now - e.seconds) /
                   apq_pkg::WORD_W'(apq_pkg::SECONDS_PER_MINUTE);
      if (e.level > model_floor && waited_min > apq_pkg::WORD_W'(model_aging))
         return e.level - apq_pkg::LEVEL_W'(1);
      return e.level;
   endfunction

   // apply one accepted item to the model and queue the result it must give
   task automatic apply_to_queue_model(logic mode, logic [apq_pkg::REQ_W-1:0] data);
      logic [apq_pkg::WORD_W-1:0]  now;
      logic [apq_pkg::LEVEL_W-1:0] eff_best, eff_cand;
      int                          best;
      apq_pkg::entry_type          cand, win;
      queue_outcome_type           out;
      now = data[31:0];
      out = '0;
      if (mode == MODE_ADD) begin
         if (model_count >= DEPTH) begin
            out.res.status = apq_pkg::ST_FULL;
         end else begin
            model_slot[model_count].level   = data[34:32];
            model_slot[model_count].rank    = data[39:35];
            model_slot[model_count].number  = model_next_number;
            model_slot[model_count].seconds = now;
            model_next_number = model_next_number + apq_pkg::WORD_W'(1);
            model_count++;
            out.res.status = apq_pkg::ST_ADDED;
         end
      end else if (model_count == 0) begin
         out.res.status = apq_pkg::ST_EMPTY;
      end else begin
         // scan for the best entry: aged level, then rank, then arrival number
         best = 0;
         eff_best = promoted_level(model_slot[0], now);
         for (int i = 1; i < model_count; i++) begin
            cand = model_slot[i];
            eff_cand = promoted_level(cand, now);
            if (eff_cand < eff_best ||
                (eff_cand == eff_best && cand.rank < model_slot[best].rank) ||
                (eff_cand == eff_best && cand.rank == model_slot[best].rank &&
                 cand.number < model_slot[best].number)) begin
               best = i;
               eff_best = eff_cand;
            end
         end
         win = model_slot[best];
         out.res.status  = apq_pkg::ST_SERVED;
         out.res.level   = win.level;
         out.res.eff     = eff_best;
         out.res.rank    = win.rank;
         out.res.number  = win.number;
         out.res.seconds = win.seconds;
         out.res.wait_s  = now - win.seconds;
         // close the gap so slots keep arrival order
         for (int i = best; i + 1 < model_count; i++)
            model_slot[i] = model_slot[i + 1];
         model_count--;
      end
      out.left = CNT_W'(model_count);
      queue_results_due.push_back(out);
   endtask

   // request driver
   always @(posedge clock) begin : drive_requests
      queue_request_type nxt;
      logic              offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_to_queue_model(req_tuser, req_tdata);
            items_taken <= items_taken + 1;
            offer = 1'b0;
         end
         if (!offer && request_backlog.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            nxt = request_backlog.pop_front();
            req_tdata <= {nxt.rank, nxt.level, nxt.now};
            req_tuser <= nxt.mode;
            offer = 1'b1;
         end
         req_tvalid <= offer;
      end
   end

   // long receiver hold, started by a toggle from the sequence
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= hold_toggle;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin : check_results
      queue_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (queue_results_due.size() == 0) begin
            report_mismatch("result with nothing due, status",
                            apq_pkg::WORD_W'(rsp_tuser), '0);
         end else begin
            want = queue_results_due.pop_front();
            if (rsp_tuser != want.res.status)
               report_mismatch("status", apq_pkg::WORD_W'(rsp_tuser),
                               apq_pkg::WORD_W'(want.res.status));
            if (rsp_tdata[2:0] != want.res.level)
               report_mismatch("served_level", apq_pkg::WORD_W'(rsp_tdata[2:0]),
                               apq_pkg::WORD_W'(want.res.level));
            if (rsp_tdata[5:3] != want.res.eff)
               report_mismatch("effective_level", apq_pkg::WORD_W'(rsp_tdata[5:3]),
                               apq_pkg::WORD_W'(want.res.eff));
            if (rsp_tdata[10:6] != want.res.rank)
               report_mismatch("served_rank", apq_pkg::WORD_W'(rsp_tdata[10:6]),
                               apq_pkg::WORD_W'(want.res.rank));
            if (rsp_tdata[42:11] != want.res.number)
               report_mismatch("arrival_number", rsp_tdata[42:11], want.res.number);
            if (rsp_tdata[74:43] != want.res.seconds)
               report_mismatch("arrival_seconds", rsp_tdata[74:43], want.res.seconds);
            if (rsp_tdata[106:75] != want.res.wait_s)
               report_mismatch("wait_seconds", rsp_tdata[106:75], want.res.wait_s);
            if (rsp_tdata[106+CNT_W:107] != want.left)
               report_mismatch("entries_left", apq_pkg::WORD_W'(rsp_tdata[106+CNT_W:107]),
                               apq_pkg::WORD_W'(want.left));
         end
      end
   end

   task automatic push_request(logic mode, logic [apq_pkg::WORD_W-1:0] now,
                               logic [apq_pkg::LEVEL_W-1:0] level,
                               logic [apq_pkg::RANK_W-1:0] rank);
      queue_request_type r;
      r.mode  = mode;
      r.now   = now;
      r.level = level;
      r.rank  = rank;
      request_backlog.push_back(r);
      items_pushed++;
   endtask

   task automatic write_register(apq_pkg::csr_index_type idx,
                                 logic [apq_pkg::AGE_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == apq_pkg::CSR_AGING_MINUTES)
         model_aging = value;
      else
         model_floor = value[apq_pkg::FLOOR_W-1:0];
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // sender stops until every item is taken, every result is back and the block is quiet
   task automatic wait_queue_drained();
      while (request_backlog.size() != 0 || items_taken < items_pushed ||
             queue_results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // edges of the fields, full and empty queue, ties, aging and a wrapped wait
   task automatic queue_directed_requests();
      push_request(MODE_SERVE, 32'h0000_0000, 3'd0, 5'd0);
      push_request(MODE_ADD,   32'hFFFF_FF00, 3'd4, 5'd16);
      push_request(MODE_ADD,   32'h0000_0000, 3'd1, 5'd1);
      push_request(MODE_ADD,   32'h0000_0000, 3'd1, 5'd1);
      push_request(MODE_ADD,   32'h0000_0000, 3'd3, 5'd5);
      push_request(MODE_ADD,   32'h0000_0000, 3'd2, 5'd5);
      push_request(MODE_ADD,   32'h0000_0000, 3'd0, 5'd0);
      push_request(MODE_ADD,   32'h0000_0000, 3'd7, 5'd31);
      push_request(MODE_ADD,   32'hFFFF_FFFF, 3'd4, 5'd1);
      push_request(MODE_ADD,   32'd100,       3'd3, 5'd16);
      push_request(MODE_ADD,   32'd100,       3'd4, 5'd1);
      push_request(MODE_ADD,   32'd200,       3'd2, 5'd2);
      push_request(MODE_ADD,   32'd200,       3'd5, 5'd10);
      push_request(MODE_ADD,   32'd300,       3'd1, 5'd16);
      push_request(MODE_ADD,   32'd300,       3'd6, 5'd0);
      push_request(MODE_ADD,   32'd400,       3'd3, 5'd5);
      push_request(MODE_ADD,   32'd400,       3'd4, 5'd16);
      // queue is full now
      push_request(MODE_ADD,   32'd500,       3'd1, 5'd1);
      push_request(MODE_SERVE, 32'd1000,      3'd0, 5'd0);
      push_request(MODE_SERVE, 32'd3000,      3'd0, 5'd0);
      push_request(MODE_SERVE, 32'hFFFF_FFFF, 3'd0, 5'd0);
      push_request(MODE_SERVE, 32'h0000_0100, 3'd0, 5'd0);
      push_request(MODE_SERVE, 32'h8000_0000, 3'd0, 5'd0);
   endtask

   // bursts of adds and serves so the queue swings between empty and full
   task automatic queue_random_requests(int count);
      logic [apq_pkg::WORD_W-1:0]  now;
      logic [apq_pkg::LEVEL_W-1:0] lv;
      logic [apq_pkg::RANK_W-1:0]  rk;
      int                          pick;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_mode = 1'($urandom_range(1));
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
         pick = $urandom_range(99);
         if (pick < 80)
            stim_seconds = stim_seconds + $urandom_range(0, 400);
         else if (pick < 95)
            stim_seconds = stim_seconds + $urandom_range(0, 5000);
         else
            stim_seconds = stim_seconds + $urandom_range(0, 100000);
         now = ($urandom_range(99) < 5) ? $urandom : stim_seconds;
         lv = ($urandom_range(99) < 90) ? apq_pkg::LEVEL_W'($urandom_range(1, 4)) :
                                          apq_pkg::LEVEL_W'($urandom_range(0, 7));
         rk = ($urandom_range(99) < 90) ? apq_pkg::RANK_W'($urandom_range(1, 16)) :
                                          apq_pkg::RANK_W'($urandom_range(0, 31));
         push_request(burst_mode, now, lv, rk);
      end
   endtask

   // test sequence
   initial begin
      int base;
      model_count       = 0;
      model_next_number = '0;
      model_aging       = apq_pkg::AGING_RESET;
      model_floor       = apq_pkg::FLOOR_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register defaults, sender idles little, receiver often
      set_idling(10, 76);
      @(negedge clock);
      queue_directed_requests();
      queue_random_requests(100);
      wait_queue_drained();

      // shortest aging limit: any whole minute promotes, floor zero
      write_register(apq_pkg::CSR_AGING_MINUTES, 10'd0);
      write_register(apq_pkg::CSR_NO_AGING_FLOOR, 10'd0);
      @(negedge clock);
      queue_random_requests(100);
      wait_queue_drained();

      // longest aging limit, floor 4; idling swapped
      set_idling(76, 10);
      write_register(apq_pkg::CSR_AGING_MINUTES, 10'd1023);
      write_register(apq_pkg::CSR_NO_AGING_FLOOR, {7'($urandom), 3'd4});
      @(negedge clock);
      queue_random_requests(100);
      wait_queue_drained();

      // random limit, floor at the top level so that no entry ages
      write_register(apq_pkg::CSR_AGING_MINUTES, 10'($urandom_range(2, 1022)));
      write_register(apq_pkg::CSR_NO_AGING_FLOOR, {7'($urandom), 3'd7});
      @(negedge clock);
      queue_random_requests(100);
      wait_queue_drained();

      // no idling, with one long receiver hold while items keep coming
      set_idling(0, 0);
      write_register(apq_pkg::CSR_AGING_MINUTES, 10'd1);
      write_register(apq_pkg::CSR_NO_AGING_FLOOR, 10'd1);
      @(negedge clock);
      base = items_taken;
      queue_random_requests(100);
      while (items_taken < base + 5)
         @(posedge clock);
      hold_toggle <= ~hold_toggle;
      wait_queue_drained();

      repeat (50) @(posedge clock);
      while (queue_results_due.size() != 0) begin
         report_mismatch("result never came, status", '0,
                         apq_pkg::WORD_W'(queue_results_due[0].res.status));
         void'(queue_results_due.pop_front());
      end
      if (error_count == 0)
         $display("tb_aging_priority_queue_core: done, clean");
      else
         $display("tb_aging_priority_queue_core: done, errors");
      $finish;
   end

endmodule
